[design/acmac_pkg.sv]
package acmac_pkg;

   localparam int unsigned BLOCK_W    = 128;
   localparam int unsigned HALF_W     = 64;
   localparam int unsigned ROUNDS     = 10;
   localparam int unsigned RK_DEPTH   = ROUNDS + 1;
   localparam int unsigned RND_W      = 4;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned BLOCK_BYTES = 16;

   localparam logic [RND_W-1:0]     LAST_ROUND = RND_W'(ROUNDS);
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 8'd1;
   localparam logic [7:0]           PAD_BYTE = 8'h80;
   localparam logic [7:0]           DBL_POLY = 8'h87;
   localparam logic [7:0]           MIX_POLY = 8'h1b;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_KEXP = 4'b0010,
      ST_ENC  = 4'b0100,
      ST_HOLD = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      MODE_SUBKEY = 2'd0,
      MODE_CHAIN  = 2'd1,
      MODE_MAC    = 2'd2
   } mode_type;

   localparam logic [7:0] RCON [RK_DEPTH] = '{
      8'h8d, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] p);
      xtime = p[7] ? ({p[6:0], 1'b0} ^ MIX_POLY) : {p[6:0], 1'b0};
   endfunction

   function automatic logic [BLOCK_W-1:0] dbl(input logic [BLOCK_W-1:0] x);
      dbl = {x[BLOCK_W-2:0], 1'b0} ^ (x[BLOCK_W-1] ? BLOCK_W'(DBL_POLY) : '0);
   endfunction

   // next round key from the previous one
   function automatic logic [BLOCK_W-1:0] key_step(input logic [BLOCK_W-1:0] rk,
                                                   input logic [7:0] rc);
      logic [31:0] t;
      logic [31:0] w0;
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] w3;
      t  = {SBOX[rk[23:16]], SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
      w0 = rk[127:96] ^ t ^ {rc, 24'd0};
      w1 = rk[95:64] ^ w0;
      w2 = rk[63:32] ^ w1;
      w3 = rk[31:0] ^ w2;
      key_step = {w0, w1, w2, w3};
   endfunction

endpackage

[design/acmac_if.sv]
interface acmac_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  byte_count;
   logic        last_block;

   modport source (output valid, block_high, block_low, byte_count, last_block, input ready);
   modport sink (input valid, block_high, block_low, byte_count, last_block, output ready);
endinterface

interface acmac_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] mac_high;
   logic [63:0] mac_low;

   modport source (output valid, mac_high, mac_low, input ready);
   modport sink (input valid, mac_high, mac_low, output ready);
endinterface

[design/acmac_ram.sv]
module acmac_ram #(
   parameter int unsigned WIDTH = 128,
   parameter int unsigned DEPTH = 11
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[design/acmac_round.sv]
module acmac_round (
   input  logic [127:0] state_in,
   input  logic         final_round,
   output logic [127:0] state_out
);
   import acmac_pkg::*;

   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] m [16];

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         s[i] = SBOX[state_in[127-8*i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[4*c+r] = s[4*((c+r)%4)+r];
         end
      end
      for (int c = 0; c < 4; c++) begin
         m[4*c]   = t[4*c] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c]^t[4*c+1]);
         m[4*c+1] = t[4*c+1] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+1]^t[4*c+2]);
         m[4*c+2] = t[4*c+2] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+2]^t[4*c+3]);
         m[4*c+3] = t[4*c+3] ^ (t[4*c]^t[4*c+1]^t[4*c+2]^t[4*c+3]) ^ xtime(t[4*c+3]^t[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         state_out[127-8*i -: 8] = final_round ? t[i] : m[i];
      end
   end
endmodule

[design/aes128_cmac_engine.sv]
// AES-128 CMAC engine. Each request is one 16-byte block of the message;
// the MAC comes back as one response after the block marked last. A block
// is taken in the idle state and then makes its passes through the single
// round unit, one pass per cycle, the initial key addition in the first of
// them, with the round keys read from an 11-entry round key RAM. Writing a
// key register (and leaving reset) starts key expansion into the RAM followed
// by the encryption of the zero block for the subkeys; no request is taken
// until both are done.
module aes128_cmac_engine (
   input  logic                            clock,
   input  logic                            reset,
   acmac_req_if.sink                       req_if,
   acmac_rsp_if.source                     rsp_if,
   input  logic                            csr_write_en,
   input  logic [acmac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                     csr_write_data
);
   import acmac_pkg::*;

   state_type            state_ff, state_in;
   mode_type             mode_ff, mode_in;
   logic [RND_W-1:0]     cnt_ff, cnt_in;
   logic [BLOCK_W-1:0]   data_ff, data_in;
   logic [BLOCK_W-1:0]   rk_ff, rk_in;
   logic [HALF_W-1:0]    key_high_ff, key_high_in;
   logic [HALF_W-1:0]    key_low_ff, key_low_in;
   logic [BLOCK_W-1:0]   k1_ff, k1_in;
   logic [BLOCK_W-1:0]   k2_ff, k2_in;
   logic [BLOCK_W-1:0]   chain_ff, chain_in;
   logic [BLOCK_W-1:0]   mac_ff, mac_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [BLOCK_W-1:0]   rk_next;
   logic [BLOCK_W-1:0]   rk_rd;
   logic [RND_W-1:0]     rd_addr;
   logic [BLOCK_W-1:0]   round_out;
   logic [BLOCK_W-1:0]   enc_next;
   logic [BLOCK_W-1:0]   blk;
   logic [BLOCK_W-1:0]   blk_pad;
   logic                 out_free;
   logic                 key_write;

   assign rk_next = (cnt_ff == '0) ? {key_high_ff, key_low_ff} : key_step(rk_ff, RCON[cnt_ff]);
   assign rd_addr = (state_ff == ST_ENC && cnt_ff != LAST_ROUND) ?
                    RND_W'(cnt_ff + 4'd1) : '0;

   acmac_ram #(.WIDTH(BLOCK_W), .DEPTH(RK_DEPTH)) u_rk_ram (
      .clock   (clock),
      .wr_en   (state_ff == ST_KEXP),
      .wr_addr (cnt_ff),
      .wr_data (rk_next),
      .rd_addr (rd_addr),
      .rd_data (rk_rd)
   );

   acmac_round u_round (
      .state_in    (data_ff),
      .final_round (cnt_ff == LAST_ROUND),
      .state_out   (round_out)
   );

   assign enc_next = ((cnt_ff == '0) ? data_ff : round_out) ^ rk_rd;

   // short last block: keep leading bytes, pad marker, zeros after
   always_comb begin
      blk = {req_if.block_high, req_if.block_low};
      for (int i = 0; i < BLOCK_BYTES; i++) begin
         if (COUNT_W'(i) < req_if.byte_count) begin
            blk_pad[127-8*i -: 8] = blk[127-8*i -: 8];
         end else if (COUNT_W'(i) == req_if.byte_count) begin
            blk_pad[127-8*i -: 8] = PAD_BYTE;
         end else begin
            blk_pad[127-8*i -: 8] = 8'd0;
         end
      end
   end

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign key_write     = csr_write_en && (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_LOW);
   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.mac_high = mac_ff[127:64];
   assign rsp_if.mac_low  = mac_ff[63:0];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      data_in      = data_ff;
      rk_in        = rk_ff;
      key_high_in  = key_high_ff;
      key_low_in   = key_low_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      chain_in     = chain_ff;
      mac_in       = mac_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               if (!req_if.last_block) begin
                  data_in = chain_ff ^ blk;
                  mode_in = MODE_CHAIN;
               end else if (req_if.byte_count >= COUNT_W'(BLOCK_BYTES)) begin
                  data_in = chain_ff ^ blk ^ k1_ff;
                  mode_in = MODE_MAC;
               end else begin
                  data_in = chain_ff ^ blk_pad ^ k2_ff;
                  mode_in = MODE_MAC;
               end
               cnt_in   = '0;
               state_in = ST_ENC;
            end
         end
         ST_KEXP: begin
            rk_in = rk_next;
            cnt_in = RND_W'(cnt_ff + 4'd1);
            if (cnt_ff == LAST_ROUND) begin
               cnt_in   = '0;
               data_in  = '0;
               mode_in  = MODE_SUBKEY;
               state_in = ST_ENC;
            end
         end
         ST_ENC: begin
            data_in = enc_next;
            cnt_in  = RND_W'(cnt_ff + 4'd1);
            if (cnt_ff == LAST_ROUND) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
               case (mode_ff)
                  MODE_SUBKEY: begin
                     k1_in = dbl(enc_next);
                     k2_in = dbl(dbl(enc_next));
                  end
                  MODE_CHAIN: begin
                     chain_in = enc_next;
                  end
                  MODE_MAC: begin
                     if (out_free) begin
                        mac_in       = enc_next;
                        rsp_valid_in = 1'b1;
                        chain_in     = '0;
                     end else begin
                        state_in = ST_HOLD;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               mac_in       = data_ff;
               rsp_valid_in = 1'b1;
               chain_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (key_write) begin
         if (csr_index == CSR_KEY_HIGH) begin
            key_high_in = csr_write_data;
         end else begin
            key_low_in = csr_write_data;
         end
         cnt_in   = '0;
         state_in = ST_KEXP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_KEXP;
         mode_ff      <= MODE_SUBKEY;
         cnt_ff       <= '0;
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         chain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      data_ff <= data_in;
      rk_ff   <= rk_in;
      k1_ff   <= k1_in;
      k2_ff   <= k2_in;
      mac_ff  <= mac_in;
   end

`ifndef SYNTH
   a_req_starts_enc: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready && !key_write) |=> (state_ff == ST_ENC && cnt_ff == '0))
      else $error("request did not start encryption");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_ENC || state_ff == ST_HOLD))
      else $error("response raised outside encryption");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ENC || state_ff == ST_KEXP) |-> (cnt_ff <= LAST_ROUND))
      else $error("round counter out of range");

   a_key_write_restarts: assert property (@(posedge clock) disable iff (reset)
      key_write |=> (state_ff == ST_KEXP && cnt_ff == '0))
      else $error("key write did not restart expansion");
`endif
endmodule

[tb/sv/acmac_checker.sv]
`timescale 1ns / 1ps

module acmac_checker (
   input  logic                            clock,
   input  logic                            reset,
   acmac_req_if                            req_mon,
   acmac_rsp_if                            rsp_mon,
   input  logic                            csr_write_en,
   input  logic [acmac_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                     csr_write_data,
   output int                              fail_count,
   output int                              pending
);
   import acmac_pkg::*;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } mac_type;

   logic [63:0]  key_hi;
   logic [63:0]  key_lo;
   logic [31:0]  sched [44];
   logic [127:0] sub_full;
   logic [127:0] sub_short;
   logic [127:0] chain;
   mac_type      mac_q [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic logic [7:0] gf_mul2(input logic [7:0] b);
      return b[7] ? ({b[6:0], 1'b0} ^ 8'h1b) : {b[6:0], 1'b0};
   endfunction

   function automatic logic [127:0] times_x(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
   endfunction

   function automatic logic [127:0] round_key(input int rnd);
      return {sched[4*rnd], sched[4*rnd+1], sched[4*rnd+2], sched[4*rnd+3]};
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] pt);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [127:0] x;
      logic [7:0]   a0, a1, a2, a3, m;
      x = pt ^ round_key(0);
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int i = 0; i < 16; i++) s[i] = SBOX[x[127-8*i -: 8]];
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (rnd < 10) begin
               m = a0 ^ a1 ^ a2 ^ a3;
               s[4*c]   = a0 ^ m ^ gf_mul2(a0 ^ a1);
               s[4*c+1] = a1 ^ m ^ gf_mul2(a1 ^ a2);
               s[4*c+2] = a2 ^ m ^ gf_mul2(a2 ^ a3);
               s[4*c+3] = a3 ^ m ^ gf_mul2(a3 ^ a0);
            end else begin
               s[4*c] = a0; s[4*c+1] = a1; s[4*c+2] = a2; s[4*c+3] = a3;
            end
         end
         for (int i = 0; i < 16; i++) x[127-8*i -: 8] = s[i];
         x = x ^ round_key(rnd);
      end
      return x;
   endfunction

   task automatic rekey();
      logic [31:0]  w;
      logic [7:0]   rc;
      logic [127:0] zero_enc;
      rc = 8'h01;
      sched[0] = key_hi[63:32];
      sched[1] = key_hi[31:0];
      sched[2] = key_lo[63:32];
      sched[3] = key_lo[31:0];
      for (int i = 4; i < 44; i++) begin
         w = sched[i-1];
         if (i % 4 == 0) begin
            w = {SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]} ^ {rc, 24'd0};
            rc = gf_mul2(rc);
         end
         sched[i] = sched[i-4] ^ w;
      end
      zero_enc  = aes_encrypt(128'h0);
      sub_full  = times_x(zero_enc);
      sub_short = times_x(sub_full);
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   task automatic absorb_request();
      logic [127:0] blk;
      logic [127:0] keep;
      int           n;
      mac_type      m;
      blk = {req_mon.block_high, req_mon.block_low};
      n   = int'(req_mon.byte_count);
      if (!req_mon.last_block) begin
         chain = aes_encrypt(chain ^ blk);
      end else begin
         if (n >= 16) begin
            blk = blk ^ sub_full;
         end else begin
            keep = (n == 0) ? 128'h0 : ({128{1'b1}} << (128 - 8*n));
            blk  = (blk & keep) | (128'h80 << (120 - 8*n));
            blk  = blk ^ sub_short;
         end
         m = aes_encrypt(chain ^ blk);
         mac_q.push_back(m);
         chain = '0;
      end
   endtask

   always @(posedge clock) begin
      mac_type want;
      if (reset) begin
         key_hi = '0;
         key_lo = '0;
         chain  = '0;
         rekey();
         mac_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (mac_q.size() == 0) begin
               report("mac with no request waiting", rsp_mon.mac_high, 64'h0);
            end else begin
               want = mac_q.pop_front();
               if (rsp_mon.mac_high !== want.hi) report("mac_high", rsp_mon.mac_high, want.hi);
               if (rsp_mon.mac_low !== want.lo) report("mac_low", rsp_mon.mac_low, want.lo);
            end
         end
         if (req_mon.valid && req_mon.ready) absorb_request();
         if (csr_write_en) begin
            if (csr_index == CSR_KEY_HIGH) begin
               key_hi = csr_write_data;
               rekey();
            end else if (csr_index == CSR_KEY_LOW) begin
               key_lo = csr_write_data;
               rekey();
            end
         end
      end
      pending = mac_q.size();
   end

endmodule

[tb/sv/tb_aes128_cmac_engine.sv]
`timescale 1ns / 1ps

module tb_aes128_cmac_engine;
   import acmac_pkg::*;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_write_data;
   int                   fail_count;
   int                   pending;
   int                   stall_mode;
   int                   stall_cnt;

   acmac_req_if req_bus ();
   acmac_rsp_if rsp_bus ();

   aes128_cmac_engine u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_bus),
      .rsp_if         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   acmac_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("tb_aes128_cmac_engine NOT OK");
      $finish;
   end

   // receiver stall pattern in one of four randomly chosen modes
   initial begin
      rsp_bus.ready = 1'b0;
      stall_mode    = 0;
      stall_cnt     = 0;
   end

   always @(posedge clock) begin
      if (stall_cnt == 63) stall_mode <= $urandom_range(0, 3);
      stall_cnt <= (stall_cnt + 1) % 64;
      case (stall_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
         2: rsp_bus.ready <= ((stall_cnt % 10) >= 7);
         default: rsp_bus.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   task automatic send(input logic [63:0] hi, input logic [63:0] lo,
                       input logic [4:0] cnt, input logic last);
      req_bus.valid      <= 1'b1;
      req_bus.block_high <= hi;
      req_bus.block_low  <= lo;
      req_bus.byte_count <= cnt;
      req_bus.last_block <= last;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic pause(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if ($urandom_range(0, 5) == 0) pause($urandom_range(1, 8));
   endtask

   task automatic drain();
      pause(1);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [4:0] rand_count();
      case ($urandom_range(0, 3))
         0: return 5'd16;
         1: return 5'($urandom_range(17, 31));
         default: return 5'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic random_messages(input int items);
      int sent;
      int len;
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(1, 6);
         for (int b = 0; b < len; b++) begin
            send(rand64(), rand64(), rand_count(), b == len - 1);
            maybe_gap();
            if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 20));
         end
         sent += len;
      end
   endtask

   initial begin
      reset              = 1'b1;
      csr_write_en       = 1'b0;
      csr_index          = '0;
      csr_write_data     = '0;
      req_bus.valid      = 1'b0;
      req_bus.block_high = '0;
      req_bus.block_low  = '0;
      req_bus.byte_count = '0;
      req_bus.last_block = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, all-zero reset key
      send(64'h0, 64'h0, 5'd0, 1'b1);
      send(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd16, 1'b1);
      send(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd31, 1'b1);
      send(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd15, 1'b1);
      send(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 5'd1, 1'b1);
      send(64'h0, 64'h0, 5'd31, 1'b0);
      send(64'hffff_ffff_ffff_ffff, 64'h0, 5'd7, 1'b0);
      send(64'h0, 64'hffff_ffff_ffff_ffff, 5'd8, 1'b1);
      drain();

      write_csr(CSR_KEY_HIGH, 64'h2b7e_1516_28ae_d2a6);
      write_csr(CSR_KEY_LOW, 64'habf7_1588_09cf_4f3c);
      send(64'h6bc1_bee2_2e40_9f96, 64'he93d_7e11_7393_172a, 5'd16, 1'b1);
      send(64'h0, 64'h0, 5'd0, 1'b1);
      send(64'h6bc1_bee2_2e40_9f96, 64'he93d_7e11_7393_172a, 5'd0, 1'b0);
      send(64'hae2d_8a57_1e03_ac9c, 64'h9eb7_6fac_45af_8e51, 5'd0, 1'b0);
      send(64'h30c8_1c46_a35c_e411, 64'h0, 5'd8, 1'b1);
      send(rand64(), rand64(), 5'd17, 1'b0);
      drain();

      // key change in the middle of a message
      send(rand64(), rand64(), 5'd3, 1'b0);
      send(rand64(), rand64(), 5'd16, 1'b0);
      drain();
      write_csr(CSR_KEY_HIGH, 64'hffff_ffff_ffff_ffff);
      write_csr(CSR_KEY_LOW, 64'hffff_ffff_ffff_ffff);
      write_csr(8'd2, rand64());
      write_csr(8'hff, rand64());
      send(rand64(), rand64(), 5'd9, 1'b1);
      send(rand64(), rand64(), 5'd12, 1'b1);
      drain();

      random_messages(120);
      drain();
      write_csr(CSR_KEY_HIGH, 64'h0);
      write_csr(CSR_KEY_LOW, 64'h0);
      random_messages(100);
      drain();
      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_KEY_HIGH, rand64());
         write_csr(CSR_KEY_LOW, rand64());
         random_messages(100);
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("tb_aes128_cmac_engine OK");
      end else begin
         $display("tb_aes128_cmac_engine NOT OK");
      end
      $finish;
   end

endmodule

[filelist.f]
design/acmac_pkg.sv
design/acmac_if.sv
design/acmac_ram.sv
design/acmac_round.sv
design/aes128_cmac_engine.sv
tb/sv/acmac_checker.sv
tb/sv/tb_aes128_cmac_engine.sv
